/* design/aou_pkg.sv */
// Shared types and constants of the Adam optimizer update block.
// No dependencies; aou_div, aou_sqrt, aou_front, aou_back and the top-level file import it.
package aou_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned MomW   = 32;
  localparam int unsigned SecW   = 48;
  localparam int unsigned PowW   = 33;
  localparam int unsigned DvdW   = 80;
  localparam int unsigned DvrW   = 34;
  localparam int unsigned CntW   = 7;

  localparam logic [33:0] ONE_Q32 = 34'h1_0000_0000;

  localparam logic [31:0] BETA1_RST = 32'd3865470566;
  localparam logic [31:0] BETA2_RST = 32'd4290672329;
  localparam logic [31:0] ALPHA_RST = 32'd4294967;
  localparam logic [31:0] EPS_RST   = 32'd429;

  localparam logic [1:0] CFG_BETA1 = 2'd0;
  localparam logic [1:0] CFG_BETA2 = 2'd1;
  localparam logic [1:0] CFG_ALPHA = 2'd2;
  localparam logic [1:0] CFG_EPS   = 2'd3;

  typedef struct packed {
    logic [31:0] beta1;
    logic [31:0] beta2;
    logic [31:0] alpha;
    logic [31:0] eps;
  } cfg_t;

  typedef struct packed {
    logic signed [DataW-1:0] weight;
    logic signed [DataW-1:0] gradient;
    logic [IdxW-1:0]         index;
    logic                    in_range;
    logic                    last;
  } item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_READ,
    ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4,
    ST_MUL5, ST_MUL6, ST_MUL7, ST_MUL8, ST_MUL9,
    ST_DIVM_GO, ST_DIVM, ST_DIVV_GO, ST_DIVV,
    ST_SQRT_GO, ST_SQRT, ST_DEN, ST_DIVS_GO, ST_DIVS, ST_FIN
  } state_e;

endpackage

/* design/aou_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module aou_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/aou_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on aou_pkg; the dividend arrives MSB-aligned with its bit count.
module aou_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [aou_pkg::DvdW-1:0]    dividend_i,
  input  logic [aou_pkg::CntW-1:0]    nbits_i,
  input  logic [aou_pkg::DvrW-1:0]    divisor_i,
  output logic                        done_o,
  output logic [aou_pkg::DvdW-1:0]    quotient_o
);
  import aou_pkg::*;

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DvdW-1:0] dvd_q, quo_q;
  logic [DvrW-1:0] dvr_q, rem_q;
  logic [DvrW:0]   trial;
  logic            fits;

  assign trial = {rem_q, dvd_q[DvdW-1]};
  assign fits  = trial >= {1'b0, dvr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= nbits_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvr_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
      rem_q <= fits ? DvrW'(trial - {1'b0, dvr_q}) : DvrW'(trial);
      quo_q <= {quo_q[DvdW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* design/aou_sqrt.sv */
// Iterative integer square root of a 64-bit value, one root bit per cycle.
// Depends on aou_pkg.
module aou_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  import aou_pkg::*;

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [63:0] x_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [35:0] cand, test;
  logic        fits;

  assign cand = {rem_q, x_q[63:62]};
  assign test = {2'b00, root_q, 2'b01};
  assign fits = cand >= test;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd1);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[61:0], 2'b00};
      rem_q  <= fits ? 34'(cand - test) : 34'(cand);
      root_q <= {root_q[30:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* design/aou_front.sv */
// Front end: accepts beats, checks the index range, holds a two-entry queue.
// Depends on aou_pkg.
module aou_front #(
  parameter int unsigned VEC_SIZE = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [79:0]           s_axis_tdata,
  input  logic                  s_axis_tlast,
  input  logic                  clearing_i,
  input  logic                  pop_i,
  output aou_pkg::head_t        head_o
);
  import aou_pkg::*;

  item_t       slot_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        push;
  item_t       in_item;
  logic [16:0] idx_ext;

  assign idx_ext          = {7'b0, s_axis_tdata[73:64]};
  assign in_item.weight   = s_axis_tdata[31:0];
  assign in_item.gradient = s_axis_tdata[63:32];
  assign in_item.index    = s_axis_tdata[73:64];
  assign in_item.in_range = idx_ext < 17'(VEC_SIZE);
  assign in_item.last     = s_axis_tlast;

  assign s_axis_tready = (count_q != 2'd2) && !clearing_i;
  assign push          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_item;
    end
  end

  assign head_o.valid = count_q != 2'd0;
  assign head_o.item  = slot_q[rd_ptr_q];

endmodule

/* design/aou_back.sv */
// Back end: sequencer over a shared multiplier, divider and square root unit.
// Depends on aou_pkg, aou_ram, aou_div and aou_sqrt.
module aou_back #(
  parameter int unsigned VEC_SIZE = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  aou_pkg::head_t head_i,
  input  aou_pkg::cfg_t  cfg_i,
  input  logic           out_ready_i,
  output logic           pop_o,
  output logic           clearing_o,
  output logic           out_valid_o,
  output logic [31:0]    out_weight_o,
  output logic           out_sat_o
);
  import aou_pkg::*;

  localparam int unsigned AW = (VEC_SIZE > 1) ? $clog2(VEC_SIZE) : 1;

  state_e state_q, state_d;

  logic [AW-1:0]      clr_q;
  item_t              item_q;
  logic [16:0]        idx_ext;
  logic [AW-1:0]      addr;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr;
  logic [79:0]        ram_wdata, ram_rdata;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_q;
  logic [81:0]        acc_q;
  logic [67:0]        msum;

  logic [31:0]        m_old;
  logic [47:0]        v_old_q;
  logic [31:0]        m_q;
  logic [46:0]        gg_q;
  logic [47:0]        v_q;
  logic [PowW-1:0]    p1_q, p2_q, pow1_q, pow2_q;
  logic [33:0]        d1, d2;
  logic               neg;
  logic [31:0]        mmag, mhat_q, ag;
  logic [31:0]        lim;
  logic [47:0]        vhat_q;
  logic [32:0]        den_q, den_raw;
  logic [32:0]        eps_rnd;
  logic               sat_q;
  logic               vhat_big;

  logic               div_start, div_done;
  logic [DvdW-1:0]    div_dvd, div_quo;
  logic [CntW-1:0]    div_n;
  logic [DvrW-1:0]    div_dvr;
  logic               sqrt_start, sqrt_done;
  logic [31:0]        root;

  logic [55:0]        step;
  logic signed [57:0] wn;
  logic [31:0]        res_w_q;
  logic               res_sat_q;
  logic               out_free;
  logic               out_valid_q, out_sat_q;
  logic [31:0]        out_weight_q;

  assign idx_ext = {7'b0, item_q.index};
  assign addr    = idx_ext[AW-1:0];
  assign m_old   = item_q.in_range ? ram_rdata[31:0] : 32'd0;
  assign ag      = item_q.gradient[31] ? 32'(-item_q.gradient) : item_q.gradient;
  assign msum    = acc_q[67:0] + prod_q;
  assign d1      = ONE_Q32 - {1'b0, p1_q};
  assign d2      = ONE_Q32 - {1'b0, p2_q};
  assign neg     = m_q[31];
  assign mmag    = neg ? 32'(-m_q) : m_q;
  assign lim     = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign vhat_big = {2'b00, v_q[47:16]} >= d2;
  assign eps_rnd = {1'b0, cfg_i.eps} + 33'd128;
  assign den_raw = {1'b0, root} + {8'b0, eps_rnd[32:8]};
  assign step    = div_quo[63:8];
  assign wn      = neg ? ({{26{item_q.weight[31]}}, item_q.weight} + {2'b00, step})
                       : ({{26{item_q.weight[31]}}, item_q.weight} - {2'b00, step});
  assign out_free = !out_valid_q || out_ready_i;

  // sequencer
  always_comb begin
    state_d    = state_q;
    pop_o      = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = addr;
    ram_wdata  = {v_q, m_q};
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_dvd    = '0;
    div_n      = '0;
    div_dvr    = '0;
    sqrt_start = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == AW'(VEC_SIZE - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_MUL0;
      end
      ST_MUL0: begin
        mul_a   = {2'b00, cfg_i.beta1};
        mul_b   = {{2{m_old[31]}}, m_old};
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        mul_a   = ONE_Q32 - {2'b00, cfg_i.beta1};
        mul_b   = {{2{item_q.gradient[31]}}, item_q.gradient};
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        mul_a   = {2'b00, ag};
        mul_b   = {2'b00, ag};
        state_d = ST_MUL3;
      end
      ST_MUL3: begin
        mul_a   = {2'b00, cfg_i.beta2};
        mul_b   = {10'b0, v_old_q[23:0]};
        state_d = ST_MUL4;
      end
      ST_MUL4: begin
        mul_a   = {2'b00, cfg_i.beta2};
        mul_b   = {10'b0, v_old_q[47:24]};
        state_d = ST_MUL5;
      end
      ST_MUL5: begin
        mul_a   = ONE_Q32 - {2'b00, cfg_i.beta2};
        mul_b   = {10'b0, gg_q[23:0]};
        state_d = ST_MUL6;
      end
      ST_MUL6: begin
        mul_a   = ONE_Q32 - {2'b00, cfg_i.beta2};
        mul_b   = {11'b0, gg_q[46:24]};
        state_d = ST_MUL7;
      end
      ST_MUL7: begin
        mul_a   = {1'b0, pow1_q};
        mul_b   = {2'b00, cfg_i.beta1};
        state_d = ST_MUL8;
      end
      ST_MUL8: begin
        mul_a   = {1'b0, pow2_q};
        mul_b   = {2'b00, cfg_i.beta2};
        state_d = ST_MUL9;
      end
      ST_MUL9: state_d = ST_DIVM_GO;
      ST_DIVM_GO: begin
        div_start = 1'b1;
        div_dvd   = {mmag, 48'b0};
        div_n     = CntW'(64);
        div_dvr   = d1;
        state_d   = ST_DIVM;
      end
      ST_DIVM: if (div_done) state_d = ST_DIVV_GO;
      ST_DIVV_GO: begin
        if (vhat_big) begin
          state_d = ST_SQRT_GO;
        end else begin
          div_start = 1'b1;
          div_dvd   = {v_q, 32'b0};
          div_n     = CntW'(80);
          div_dvr   = d2;
          state_d   = ST_DIVV;
        end
      end
      ST_DIVV: if (div_done) state_d = ST_SQRT_GO;
      ST_SQRT_GO: begin
        sqrt_start = 1'b1;
        state_d    = ST_SQRT;
      end
      ST_SQRT: if (sqrt_done) state_d = ST_DEN;
      ST_DEN: begin
        mul_a   = {2'b00, mhat_q};
        mul_b   = {2'b00, cfg_i.alpha};
        state_d = ST_DIVS_GO;
      end
      ST_DIVS_GO: begin
        div_start = 1'b1;
        div_dvd   = {prod_q[63:0], 16'b0};
        div_n     = CntW'(64);
        div_dvr   = {1'b0, den_q};
        state_d   = ST_DIVS;
      end
      ST_DIVS: if (div_done) state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          ram_we  = item_q.in_range;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pow1_q      <= PowW'(ONE_Q32);
      pow2_q      <= PowW'(ONE_Q32);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (out_ready_i) out_valid_q <= 1'b0;
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
        if (item_q.last) begin
          pow1_q <= p1_q;
          pow2_q <= p2_q;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (pop_o) begin
      item_q <= head_i.item;
      sat_q  <= 1'b0;
    end
    if (state_q == ST_FIN && out_free) begin
      out_weight_q <= res_w_q;
      out_sat_q    <= res_sat_q;
    end
    unique case (state_q)
      ST_MUL0: v_old_q <= item_q.in_range ? ram_rdata[79:32] : 48'd0;
      ST_MUL1: acc_q   <= {{14{prod_q[67]}}, prod_q};
      ST_MUL2: m_q     <= msum[63:32];
      ST_MUL3: gg_q    <= prod_q[62:16];
      ST_MUL4: acc_q   <= {14'b0, prod_q};
      ST_MUL5: acc_q   <= acc_q + ({14'b0, prod_q} << 24);
      ST_MUL6: acc_q   <= acc_q + {14'b0, prod_q};
      ST_MUL7: v_q     <= 48'((acc_q + ({14'b0, prod_q} << 24)) >> 32);
      ST_MUL8: p1_q    <= prod_q[64:32];
      ST_MUL9: p2_q    <= prod_q[64:32];
      ST_DIVM: begin
        if (div_done) begin
          if (div_quo > {48'b0, lim}) begin
            mhat_q <= lim;
            sat_q  <= 1'b1;
          end else begin
            mhat_q <= div_quo[31:0];
          end
        end
      end
      ST_DIVV_GO: begin
        if (vhat_big) begin
          vhat_q <= '1;
          sat_q  <= 1'b1;
        end
      end
      ST_DIVV: if (div_done) vhat_q <= div_quo[47:0];
      ST_SQRT: if (sqrt_done) den_q <= (den_raw == 33'd0) ? 33'd1 : den_raw;
      ST_DIVS: begin
        if (div_done) begin
          // clamp the new weight to signed 32 bits
          if (wn > 58'sh7FFF_FFFF) begin
            res_w_q   <= 32'h7FFF_FFFF;
            res_sat_q <= 1'b1;
          end else if (wn < -58'sh8000_0000) begin
            res_w_q   <= 32'h8000_0000;
            res_sat_q <= 1'b1;
          end else begin
            res_w_q   <= wn[31:0];
            res_sat_q <= sat_q;
          end
        end
      end
      default: ;
    endcase
  end

  aou_ram #(
    .WIDTH(80),
    .DEPTH(VEC_SIZE)
  ) u_moments (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(addr),
    .rdata_o(ram_rdata)
  );

  aou_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .nbits_i   (div_n),
    .divisor_i (div_dvr),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  aou_sqrt u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sqrt_start),
    .radicand_i({vhat_q, 16'b0}),
    .done_o    (sqrt_done),
    .root_o    (root)
  );

  assign clearing_o   = state_q == ST_CLEAR;
  assign out_valid_o  = out_valid_q;
  assign out_weight_o = out_weight_q;
  assign out_sat_o    = out_sat_q;

`ifndef SYNTH
  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> head_i.valid && state_q == ST_IDLE)
    else $error("queue popped without an item");
  a_no_pop_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !pop_o)
    else $error("item taken during clearing pass");
  a_store_only_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q != ST_CLEAR) |-> (state_q == ST_FIN && item_q.in_range))
    else $error("moment store outside final step");
  a_pow_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pow1_q != $past(pow1_q)) |-> ($past(state_q) == ST_FIN && $past(item_q.last)))
    else $error("power advanced without end of vector");
`endif

endmodule

/* design/adam_optimizer_update.sv */
// Adam optimizer update, one vector element per beat.
// One item at a time in the back end: ten shared-multiplier steps, two 64-bit and one
// 80-bit bit-serial divides (the 80-bit one skipped when vhat clips) and a 32-step square root.
// A two-entry input queue and an output register decouple both streams.
// After reset all VEC_SIZE entries of the moment memory are cleared; no beat is taken meanwhile.
// Configuration registers reset to their defaults; bias powers reset to 1.0.
module adam_optimizer_update #(
  parameter int unsigned VEC_SIZE = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // weight_in[31:0], gradient[63:32], element_index[73:64]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // weight_out[31:0]
  output logic        m_axis_tuser,  // saturated[0]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);
  import aou_pkg::*;

  cfg_t  cfg_q;
  head_t head;
  logic  pop, clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beta1 <= BETA1_RST;
      cfg_q.beta2 <= BETA2_RST;
      cfg_q.alpha <= ALPHA_RST;
      cfg_q.eps   <= EPS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BETA1: cfg_q.beta1 <= cfg_wdata_i;
        CFG_BETA2: cfg_q.beta2 <= cfg_wdata_i;
        CFG_ALPHA: cfg_q.alpha <= cfg_wdata_i;
        CFG_EPS:   cfg_q.eps   <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  aou_front #(
    .VEC_SIZE(VEC_SIZE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .clearing_i   (clearing),
    .pop_i        (pop),
    .head_o       (head)
  );

  aou_back #(
    .VEC_SIZE(VEC_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .cfg_i       (cfg_q),
    .out_ready_i (m_axis_tready),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .out_valid_o (m_axis_tvalid),
    .out_weight_o(m_axis_tdata),
    .out_sat_o   (m_axis_tuser)
  );

endmodule
